/* hdl/lkv_pkg.sv */
// Package for the LRU key-value cache: sizes, codes and shared types.
// No dependencies; the interfaces, the cell and the top level import it.
`default_nettype none

package lkv_pkg;

    localparam int ENTRIES = 16;
    localparam int OCC_W   = $clog2(ENTRIES + 1);
    localparam int CFG_W   = 5;
    localparam int DATA_W  = 32;

    localparam logic [CFG_W-1:0] CAP_RESET = CFG_W'(ENTRIES);

    localparam logic FUNC_GET = 1'b0;
    localparam logic FUNC_PUT = 1'b1;

    typedef logic signed [DATA_W-1:0] t_data;

    localparam t_data MISS_VALUE = '1;

    typedef struct packed {
        logic  valid;
        t_data key;
        t_data value;
    } t_entry;

    typedef struct packed {
        logic update;
        logic any_hit;
        logic evict;
    } t_cell_ctrl;

endpackage

`default_nettype wire

/* hdl/lkv_in_if.sv */
// Request channel of the LRU key-value cache: valid/ready plus get/put word.
// Depends on lkv_pkg.
`default_nettype none

interface lkv_in_if;
    import lkv_pkg::*;

    logic  valid;
    logic  ready;
    logic  func;
    t_data lookup_key;
    t_data store_value;

    modport source (output valid, func, lookup_key, store_value, input ready);
    modport sink   (input valid, func, lookup_key, store_value, output ready);
endinterface

`default_nettype wire

/* hdl/lkv_out_if.sv */
// Response channel of the LRU key-value cache: valid/ready plus lookup result.
// Depends on lkv_pkg.
`default_nettype none

interface lkv_out_if;
    import lkv_pkg::*;

    logic  valid;
    logic  ready;
    logic  found;
    t_data read_value;

    modport source (output valid, found, read_value, input ready);
    modport sink   (input valid, found, read_value, output ready);
endinterface

`default_nettype wire

/* hdl/lru_key_value_cache.sv */
// LRU key-value cache: a chain of slots kept in recency order, head most recent.
// A get's result word is registered; it is valid in the cycle after acceptance.
// Throughput: one word per cycle while the response channel is not stalled; all slots match and shift at once.
// Reset clears valid marks and occupancy and sets the capacity to 16; no clearing pass.
// Depends on lkv_pkg, lkv_in_if, lkv_out_if and lkv_cell.
`default_nettype none

module lru_key_value_cache (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    lkv_in_if.sink                     i_in,
    lkv_out_if.source                  o_out,
    input  wire                        i_cfg_we,
    input  wire [lkv_pkg::CFG_W-1:0]   i_cfg_data
);
    import lkv_pkg::*;

    logic [CFG_W-1:0] r_capacity;
    logic [OCC_W-1:0] r_occupancy;
    logic [OCC_W-1:0] n_occupancy;
    logic [OCC_W-1:0] w_eff_cap;
    logic             r_out_valid;
    logic             r_found;
    t_data            r_read_value;

    t_entry           w_entry [ENTRIES];
    t_data            w_match_value [ENTRIES];
    logic             w_chain [ENTRIES+1];
    logic [ENTRIES-1:0] w_match;
    t_entry           w_head;
    t_cell_ctrl       w_ctrl;
    t_data            w_hit_value;
    logic             w_accept;
    logic             w_is_put;

    assign i_in.ready  = !r_out_valid || o_out.ready;
    assign w_accept    = i_in.valid && i_in.ready;
    assign w_is_put    = (i_in.func == FUNC_PUT);

    always_comb begin
        priority if (r_capacity == '0) begin
            w_eff_cap = OCC_W'(1);
        end else if (OCC_W'(r_capacity) > OCC_W'(ENTRIES)) begin
            w_eff_cap = OCC_W'(ENTRIES);
        end else begin
            w_eff_cap = OCC_W'(r_capacity);
        end
    end

    always_comb begin
        w_hit_value = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            w_hit_value = w_hit_value | w_match_value[i];
        end
    end

    always_comb begin
        w_ctrl.any_hit = w_chain[0];
        w_ctrl.evict   = (r_occupancy >= w_eff_cap);
        w_ctrl.update  = w_accept && (w_is_put || w_chain[0]);
        w_head.valid   = 1'b1;
        w_head.key     = i_in.lookup_key;
        w_head.value   = w_is_put ? i_in.store_value : w_hit_value;
    end

    assign w_chain[ENTRIES] = 1'b0;

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        t_entry w_prev;
        if (g == 0) begin : g_head
            assign w_prev = w_head;
        end else begin : g_body
            assign w_prev = w_entry[g-1];
        end

        lkv_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_key         (i_in.lookup_key),
            .i_ctrl        (w_ctrl),
            .i_prev        (w_prev),
            .i_tail_hit    (w_chain[g+1]),
            .o_entry       (w_entry[g]),
            .o_hit_chain   (w_chain[g]),
            .o_match_value (w_match_value[g])
        );

        assign w_match[g] = w_entry[g].valid && (w_entry[g].key == i_in.lookup_key);
    end

    always_comb begin
        n_occupancy = r_occupancy;
        if (w_accept && w_is_put && !w_chain[0] && !w_ctrl.evict) begin
            n_occupancy = r_occupancy + OCC_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity  <= CAP_RESET;
            r_occupancy <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_capacity <= i_cfg_data;
            end
            r_occupancy <= n_occupancy;
            if (w_accept && !w_is_put) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && !w_is_put) begin
            r_found      <= w_chain[0];
            r_read_value <= w_chain[0] ? w_hit_value : MISS_VALUE;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.found      = r_found;
    assign o_out.read_value = r_read_value;

    logic [ENTRIES-1:0] w_valid_bits;
    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            w_valid_bits[i] = w_entry[i].valid;
        end
    end

    a_key_unique: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid |-> $onehot0(w_match))
        else $error("lookup key matches more than one slot");

    a_occ_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_valid_bits) == 32'(r_occupancy))
        else $error("occupancy disagrees with valid slots");

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occupancy <= OCC_W'(ENTRIES))
        else $error("occupancy above slot count");

endmodule

`default_nettype wire

/* hdl/lkv_cell.sv */
// One cache slot of the recency-ordered chain: key, value, valid mark.
// Depends on lkv_pkg; loads its upstream neighbor's entry on a shift.
`default_nettype none

module lkv_cell (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  lkv_pkg::t_data       i_key,
    input  lkv_pkg::t_cell_ctrl  i_ctrl,
    input  lkv_pkg::t_entry      i_prev,
    input  wire                  i_tail_hit,
    output lkv_pkg::t_entry      o_entry,
    output logic                 o_hit_chain,
    output lkv_pkg::t_data       o_match_value
);
    import lkv_pkg::*;

    t_entry r_entry;
    t_entry n_entry;
    logic   w_match;
    logic   w_chain;
    logic   w_load;

    always_comb begin
        w_match = r_entry.valid && (r_entry.key == i_key);
        w_chain = w_match | i_tail_hit;
        // hit: shift down to the hit slot; miss put: shift the valid run
        priority if (i_ctrl.any_hit) begin
            w_load = w_chain;
        end else if (i_ctrl.evict) begin
            w_load = r_entry.valid;
        end else begin
            w_load = i_prev.valid;
        end
        n_entry = (i_ctrl.update && w_load) ? i_prev : r_entry;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry.valid <= 1'b0;
        end else begin
            r_entry <= n_entry;
        end
    end

    assign o_entry       = r_entry;
    assign o_hit_chain   = w_chain;
    assign o_match_value = w_match ? r_entry.value : '0;

endmodule

`default_nettype wire
